/* rtl/core/gbu4x_pkg.sv */
// ----------------------------------------------------------------------------
// gbu4x_pkg
// shared types and constants of the 4x bilinear gray upscaler
// ----------------------------------------------------------------------------
package gbu4x_pkg;

  // line buffer depth default
  localparam int unsigned MaxWidthC = 4096;

  // configuration registers
  localparam int unsigned ImgWidthW   = 13;
  localparam int unsigned ImgHeightW  = 16;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 1;
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;
  localparam logic [ImgWidthW-1:0]  ImgWidthRstC  = 13'd640;
  localparam logic [ImgHeightW-1:0] ImgHeightRstC = 16'd480;

  // input word
  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [15:0] tile_row;
    logic [11:0] tile_col;
    logic [1:0]  sub_row;
    logic [7:0]  pix0;
    logic [7:0]  pix1;
    logic [7:0]  pix2;
    logic [7:0]  pix3;
    logic        last;
  } out_word_t;

  // 3x3 neighborhood, [row][col], row 0 oldest, col 0 leftmost
  typedef logic [2:0][2:0][7:0] nbhd_t;

  // tap selection for one output row of one tile
  typedef struct packed {
    logic [1:0] row_up;
    logic [1:0] row_mid;
    logic [1:0] row_dn;
    logic [1:0] col_left;
    logic [1:0] col_mid;
    logic [1:0] col_right;
    logic [1:0] sub_row;
  } tile_sel_t;

endpackage

/* rtl/core/gbu4x_line_buf.sv */
// ----------------------------------------------------------------------------
// gbu4x_line_buf
// two previous source rows, registered read with write-to-read bypass
// ----------------------------------------------------------------------------
module gbu4x_line_buf #(
  parameter  int unsigned Depth = gbu4x_pkg::MaxWidthC,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_older_i,
  input  logic [7:0]       wr_newer_i,
  output logic [7:0]       older_o,
  output logic [7:0]       newer_o
);

  logic [7:0] older_mem [Depth];
  logic [7:0] newer_mem [Depth];

  logic [7:0] older_rd_q, newer_rd_q;
  logic [7:0] byp_older_q, byp_newer_q;
  logic       byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= wr_older_i;
      newer_mem[wr_addr_i] <= wr_newer_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      older_rd_q  <= older_mem[rd_addr_i];
      newer_rd_q  <= newer_mem[rd_addr_i];
      byp_older_q <= wr_older_i;
      byp_newer_q <= wr_newer_i;
    end
  end

  // same entry written at the read edge: take the fresh data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign older_o = byp_q ? byp_older_q : older_rd_q;
  assign newer_o = byp_q ? byp_newer_q : newer_rd_q;

endmodule

/* rtl/core/gbu4x_tile_calc.sv */
// ----------------------------------------------------------------------------
// gbu4x_tile_calc
// horizontal then vertical 3-tap blend for one four-pixel output row
// ----------------------------------------------------------------------------
module gbu4x_tile_calc (
  input  gbu4x_pkg::nbhd_t      nbhd_i,
  input  gbu4x_pkg::tile_sel_t  sel_i,
  output logic [3:0][7:0]       pix_o
);
  import gbu4x_pkg::*;

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [1:0] s);
    logic [10:0] sum;
    case (s)
      2'd0:    sum = 11'(3 * a + 5 * b);
      2'd1:    sum = 11'(a + 7 * b);
      2'd2:    sum = 11'(7 * b + c);
      default: sum = 11'(5 * b + 3 * c);
    endcase
    return sum[10:3];
  endfunction

  function automatic logic [7:0] pick3(input logic [2:0][7:0] v, input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = v[0];
      2'd1:    r = v[1];
      default: r = v[2];
    endcase
    return r;
  endfunction

  logic [2:0][3:0][7:0] horiz;
  logic [3:0][2:0][7:0] vcol;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        horiz[r][k] = blend(pick3(nbhd_i[r], sel_i.col_left),
                            pick3(nbhd_i[r], sel_i.col_mid),
                            pick3(nbhd_i[r], sel_i.col_right), 2'(k));
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 3; r++) begin
        vcol[k][r] = horiz[r][k];
      end
      pix_o[k] = blend(pick3(vcol[k], sel_i.row_up),
                       pick3(vcol[k], sel_i.row_mid),
                       pick3(vcol[k], sel_i.row_dn), sel_i.sub_row);
    end
  end

endmodule

/* rtl/core/gray_bilinear_upscale_4x.sv */
// ----------------------------------------------------------------------------
// gray_bilinear_upscale_4x
// 4x bilinear enlargement of a raster-order 8-bit gray stream
// ----------------------------------------------------------------------------
// path: an accepted pixel sits in stage 1 until its last tile row word leaves;
//   its words are registered in the output register, which a stall holds
// tiles: four row words per finished tile; one tile in the interior, two on the
//   last column or last row, four at the bottom-right corner, else none
// reset: counters, column window and valid flags clear, config returns to its
//   defaults; the line memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module gray_bilinear_upscale_4x #(
  parameter int unsigned MAX_WIDTH = gbu4x_pkg::MaxWidthC
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [gbu4x_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gbu4x_pkg::CfgDataW-1:0]      cfg_data_i,
  // source pixel channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  gbu4x_pkg::in_word_t                 in_word_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gbu4x_pkg::out_word_t                out_word_o
);
  import gbu4x_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // wide enough for the width register and for MAX_WIDTH itself
  localparam int unsigned CmpW = (ColW + 1 > ImgWidthW) ? ColW + 1 : ImgWidthW;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [ImgWidthW-1:0]  width_q;
  logic [ImgHeightW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ImgWidthRstC;
      height_q <= ImgHeightRstC;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  width_q  <= cfg_data_i[ImgWidthW-1:0];
        CfgImageHeight: height_q <= cfg_data_i[ImgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, width clamps to the line buffer depth
  logic [CmpW-1:0]       width_eff;
  logic [ImgHeightW-1:0] height_eff;

  always_comb begin
    if (width_q == '0) begin
      width_eff = CmpW'(1);
    end else if (CmpW'(width_q) > CmpW'(MAX_WIDTH)) begin
      width_eff = CmpW'(MAX_WIDTH);
    end else begin
      width_eff = CmpW'(width_q);
    end
    height_eff = (height_q == '0) ? ImgHeightW'(1) : height_q;
  end

  // --------------------------------------------------------------------------
  // handshakes and stage control
  // --------------------------------------------------------------------------
  logic            in_accept;
  logic            out_load;
  logic            emit;
  logic            s1_done;
  logic            s1_valid_q;
  logic [3:0]      rem_q;     // tiles still owed by the pixel in stage 1
  logic [1:0]      sub_q;     // output row within the current tile

  assign out_load   = !out_valid_o || !out_stall_i;
  assign emit       = s1_valid_q && (rem_q != '0) && out_load;
  // last word of the last tile leaves, or the pixel owes nothing
  assign s1_done    = s1_valid_q &&
                      ((rem_q == '0) ||
                       (emit && (sub_q == 2'd3) && ((rem_q & (rem_q - 4'd1)) == '0)));
  assign in_stall_o = s1_valid_q && !s1_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // position counters, evaluated for the incoming pixel
  // --------------------------------------------------------------------------
  logic [ColW-1:0]       col_q, col_d;
  logic [ImgHeightW-1:0] row_q, row_d;
  logic [ColW-1:0]       pos_x;
  logic [ImgHeightW-1:0] pos_y;
  logic [CmpW-1:0]       x_next;
  logic [ImgHeightW:0]   y_next;
  logic                  last_col, last_row;
  logic [3:0]            tile_mask;

  always_comb begin
    pos_x = in_word_i.frame_start ? '0 : col_q;
    pos_y = in_word_i.frame_start ? '0 : row_q;
    // sizes lowered mid-frame: restart at the origin
    if ((CmpW'(pos_x) >= width_eff) || (pos_y >= height_eff)) begin
      pos_x = '0;
      pos_y = '0;
    end
    x_next   = CmpW'(pos_x) + CmpW'(1);
    y_next   = {1'b0, pos_y} + 17'd1;
    last_col = (x_next == width_eff);
    last_row = (y_next == {1'b0, height_eff});

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : y_next[ImgHeightW-1:0];
    end else begin
      col_d = x_next[ColW-1:0];
      row_d = pos_y;
    end

    // tile order: row above left, row above here, this row left, this row here
    tile_mask[0] = (pos_y != '0) && (pos_x != '0);
    tile_mask[1] = (pos_y != '0) && last_col;
    tile_mask[2] = last_row && (pos_x != '0);
    tile_mask[3] = last_row && last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: pixel whose tiles are being emitted
  // --------------------------------------------------------------------------
  logic [7:0]            s1_pix_q;
  logic [ColW-1:0]       s1_x_q;
  logic [ImgHeightW-1:0] s1_y_q;
  logic                  s1_x0_q, s1_x1_q, s1_y0_q, s1_y1_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q <= in_word_i.pixel;
      s1_x_q   <= pos_x;
      s1_y_q   <= pos_y;
      s1_x0_q  <= (pos_x == ColW'(0));
      s1_x1_q  <= (pos_x == ColW'(1));
      s1_y0_q  <= (pos_y == '0);
      s1_y1_q  <= (pos_y == ImgHeightW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rem_q      <= '0;
      sub_q      <= '0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
      rem_q      <= tile_mask;
      sub_q      <= '0;
    end else begin
      if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (emit) begin
        sub_q <= sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          rem_q <= rem_q & (rem_q - 4'd1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // line memories: read at accept, written when stage 1 retires
  // --------------------------------------------------------------------------
  logic [7:0] line_older, line_newer;

  gbu4x_line_buf #(
    .Depth (MAX_WIDTH)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_addr_i  (pos_x),
    .wr_en_i    (s1_done),
    .wr_addr_i  (s1_x_q),
    .wr_older_i (line_newer),
    .wr_newer_i (s1_pix_q),
    .older_o    (line_older),
    .newer_o    (line_newer)
  );

  // column window: previous two columns of the three rows
  logic [5:0][7:0] cwin_q;
  nbhd_t           nbhd;

  always_comb begin
    nbhd[0][2] = line_older;
    nbhd[1][2] = line_newer;
    nbhd[2][2] = s1_pix_q;
    for (int r = 0; r < 3; r++) begin
      nbhd[r][1] = cwin_q[r];
      nbhd[r][0] = cwin_q[3 + r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwin_q <= '0;
    end else if (s1_done) begin
      for (int r = 0; r < 3; r++) begin
        cwin_q[3 + r] <= cwin_q[r];
        cwin_q[r]     <= nbhd[r][2];
      end
    end
  end

  // --------------------------------------------------------------------------
  // current tile: lowest owed one, with edge-clamped taps
  // --------------------------------------------------------------------------
  logic [3:0]            cur_oh;
  logic                  cur_here_col;   // tile at this column, else the left one
  logic                  cur_this_row;   // tile on this row, else the row above
  tile_sel_t             sel;
  logic [ColW-1:0]       tile_x;
  logic [ColW+11:0]      tile_x_ext;
  logic [ImgHeightW-1:0] tile_y;
  logic [3:0][7:0]       pix;

  always_comb begin
    cur_oh       = rem_q & (~rem_q + 4'd1);
    cur_here_col = cur_oh[1] | cur_oh[3];
    cur_this_row = cur_oh[2] | cur_oh[3];

    if (cur_this_row) begin
      sel.row_up  = s1_y0_q ? 2'd2 : 2'd1;
      sel.row_mid = 2'd2;
    end else begin
      sel.row_up  = s1_y1_q ? 2'd1 : 2'd0;
      sel.row_mid = 2'd1;
    end
    sel.row_dn = 2'd2;

    if (cur_here_col) begin
      sel.col_left = s1_x0_q ? 2'd2 : 2'd1;
      sel.col_mid  = 2'd2;
    end else begin
      sel.col_left = s1_x1_q ? 2'd1 : 2'd0;
      sel.col_mid  = 2'd1;
    end
    sel.col_right = 2'd2;
    sel.sub_row   = sub_q;

    tile_x     = cur_here_col ? s1_x_q : s1_x_q - ColW'(1);
    tile_x_ext = {12'b0, tile_x};
    tile_y     = cur_this_row ? s1_y_q : s1_y_q - ImgHeightW'(1);
  end

  gbu4x_tile_calc u_tile_calc (
    .nbhd_i (nbhd),
    .sel_i  (sel),
    .pix_o  (pix)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  out_word_t out_word_q;
  logic      out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q.tile_row <= tile_y;
      out_word_q.tile_col <= tile_x_ext[11:0];
      out_word_q.sub_row  <= sub_q;
      out_word_q.pix0     <= pix[0];
      out_word_q.pix1     <= pix[1];
      out_word_q.pix2     <= pix[2];
      out_word_q.pix3     <= pix[3];
      // final word of the final owed tile
      out_word_q.last     <= (sub_q == 2'd3) && ((rem_q & (rem_q - 4'd1)) == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 4x bilinear gray upscaler: pixel words go in
// through a queue-fed driver, a behavioral copy of the upscaler predicts every
// tile row word, and a monitor checks the result words in order
// ----------------------------------------------------------------------------
module testbench;
  import gbu4x_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int unsigned CycleLimit   = 1_000_000;
  // extra cycles after the last expected word, covers pixels that make no tile
  localparam int unsigned SettleCycles = 8;
  // pixels in the random part, on top of the directed phases
  localparam int unsigned RandomPixels = 216;
  localparam int unsigned ReportLimit  = 10;

  // idling pattern of one phase
  typedef enum logic [1:0] {
    FlowFree,
    FlowSrcGaps,
    FlowSinkStalls,
    FlowBoth
  } flow_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_word_t            in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_word_t           out_word_o;

  gray_bilinear_upscale_4x u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // --------------------------------------------------------------------------
  // predictor state: two source rows back, the last two columns of the three
  // rows, raster position and the register copies
  // --------------------------------------------------------------------------
  logic [7:0]  prev2_line [MaxWidthC];
  logic [7:0]  prev1_line [MaxWidthC];
  logic [7:0]  col_hist [6];   // [0..2] column x-1, [3..5] column x-2
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned img_width;
  int unsigned img_height;

  in_word_t    pending_pixels [$];  // words waiting for the driver
  out_word_t   expected_rows [$];   // predicted tile row words, oldest first

  flow_e       flow;
  bit          force_frame_start;
  bit          src_taken;
  int unsigned mismatches;
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one 3-tap weight set, s picks the output phase within the tile
  function automatic logic [7:0] tap_blend(int unsigned a, int unsigned b, int unsigned c,
                                           int unsigned s);
    int unsigned sum;
    case (s)
      0: sum = 3 * a + 5 * b;
      1: sum = a + 7 * b;
      2: sum = 7 * b + c;
      default: sum = 5 * b + 3 * c;
    endcase
    return 8'(sum >> 3);
  endfunction

  // width 0 behaves as 1, anything past the line buffer as the full buffer
  function automatic int unsigned eff_width(int unsigned w);
    if (w == 0) return 1;
    if (w > MaxWidthC) return MaxWidthC;
    return w;
  endfunction

  function automatic int unsigned eff_height(int unsigned h);
    return (h == 0) ? 1 : h;
  endfunction

  // four row words of one tile; ru/rc/rd pick neighborhood rows, kl/kc/kr columns
  task automatic push_tile(int unsigned trow, int unsigned tcol, nbhd_t nb,
                           int unsigned ru, int unsigned rc, int unsigned rd,
                           int unsigned kl, int unsigned kc, int unsigned kr);
    int unsigned rsel [3];
    logic [7:0]  horiz [3][4];
    logic [7:0]  px [4];
    out_word_t   w;
    rsel[0] = ru;
    rsel[1] = rc;
    rsel[2] = rd;
    // horizontal pass first, each kept to 8 bits
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 4; k++) begin
        horiz[i][k] = tap_blend(nb[rsel[i]][kl], nb[rsel[i]][kc], nb[rsel[i]][kr], k);
      end
    end
    // then the same weights down the three rows
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < 4; k++) begin
        px[k] = tap_blend(horiz[0][k], horiz[1][k], horiz[2][k], s);
      end
      w.tile_row = 16'(trow);
      w.tile_col = 12'(tcol);
      w.sub_row  = 2'(s);
      w.pix0     = px[0];
      w.pix1     = px[1];
      w.pix2     = px[2];
      w.pix3     = px[3];
      w.last     = 1'b0;
      expected_rows.push_back(w);
    end
  endtask

  // takes one accepted pixel word and queues the row words it finishes
  task automatic upscale_pixel(in_word_t w);
    int unsigned wd;
    int unsigned ht;
    int unsigned x;
    int unsigned y;
    int unsigned ru;
    int unsigned queued;
    nbhd_t       nb;
    out_word_t   tail;
    wd = eff_width(img_width);
    ht = eff_height(img_height);
    if (w.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    // position left behind by lowered registers restarts the frame
    if (col_pos >= wd || row_pos >= ht) begin
      row_pos = 0;
      col_pos = 0;
    end
    x = col_pos;
    y = row_pos;

    nb[0][2] = prev2_line[x];
    nb[1][2] = prev1_line[x];
    nb[2][2] = w.pixel;
    for (int r = 0; r < 3; r++) begin
      nb[r][1] = col_hist[r];
      nb[r][0] = col_hist[3 + r];
    end

    queued = expected_rows.size();
    // tiles of the row above, whose lower neighbor is now complete
    if (y >= 1) begin
      ru = (y == 1) ? 1 : 0;
      if (x >= 1) push_tile(y - 1, x - 1, nb, ru, 1, 2, (x == 1) ? 1 : 0, 1, 2);
      if (x == wd - 1) push_tile(y - 1, x, nb, ru, 1, 2, (x == 0) ? 2 : 1, 2, 2);
    end
    // bottom row replicates itself downward
    if (y == ht - 1) begin
      ru = (y == 0) ? 2 : 1;
      if (x >= 1) push_tile(y, x - 1, nb, ru, 2, 2, (x == 1) ? 1 : 0, 1, 2);
      if (x == wd - 1) push_tile(y, x, nb, ru, 2, 2, (x == 0) ? 2 : 1, 2, 2);
    end
    if (expected_rows.size() > queued) begin
      tail      = expected_rows.pop_back();
      tail.last = 1'b1;
      expected_rows.push_back(tail);
    end

    prev2_line[x] = prev1_line[x];
    prev1_line[x] = w.pixel;
    for (int r = 0; r < 3; r++) begin
      col_hist[3 + r] = col_hist[r];
      col_hist[r]     = nb[r][2];
    end
    col_pos = x + 1;
    if (col_pos >= wd) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= ht) row_pos = 0;   // frame overrun wraps to a new frame
    end
  endtask

  function automatic bit rows_match(out_word_t a, out_word_t b);
    return a.tile_row === b.tile_row && a.tile_col === b.tile_col &&
           a.sub_row === b.sub_row && a.pix0 === b.pix0 && a.pix1 === b.pix1 &&
           a.pix2 === b.pix2 && a.pix3 === b.pix3 && a.last === b.last;
  endfunction

  function automatic string fmt_row(out_word_t w);
    return $sformatf("row %0d col %0d sub %0d pix %0d %0d %0d %0d last %0d",
                     w.tile_row, w.tile_col, w.sub_row, w.pix0, w.pix1, w.pix2,
                     w.pix3, w.last);
  endfunction

  // --------------------------------------------------------------------------
  // driver: everything changes on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // a word only moves on once the last rising edge took it
      if (!in_valid_i || src_taken) begin
        if (pending_pixels.size() != 0 &&
            !((flow == FlowSrcGaps && $urandom_range(99) < 80) ||
              (flow == FlowBoth && $urandom_range(99) < 10))) begin
          in_word_i  <= pending_pixels.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= (flow == FlowSinkStalls && $urandom_range(99) < 80) ||
                     (flow == FlowBoth && $urandom_range(99) < 10);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: result check first, then prediction of the pixel taken this edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_word_t due;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("unexpected result word: %s", fmt_row(out_word_o));
          end
        end else begin
          due = expected_rows.pop_front();
          if (!rows_match(due, out_word_o)) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("mismatch: expected %s", fmt_row(due));
              $display("          actual   %s", fmt_row(out_word_o));
            end
          end
        end
      end
      src_taken = in_valid_i && !in_stall_o;
      if (src_taken) upscale_pixel(in_word_i);
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(value);
    if (idx == CfgImageWidth) img_width = value & ((1 << ImgWidthW) - 1);
    else img_height = value & ((1 << ImgHeightW) - 1);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // new frame geometry; a wider line starts with a fresh frame so that no
  // line entry is read before it was written
  task automatic set_frame(int unsigned w, int unsigned h, flow_e f);
    if (eff_width(w & ((1 << ImgWidthW) - 1)) > eff_width(img_width)) begin
      force_frame_start = 1'b1;
    end
    write_reg(CfgImageWidth, w);
    write_reg(CfgImageHeight, h);
    flow = f;
  endtask

  task automatic add_pixel(logic [7:0] p, bit fs);
    in_word_t w;
    w.pixel           = p;
    w.frame_start     = fs | force_frame_start;
    force_frame_start = 1'b0;
    pending_pixels.push_back(w);
  endtask

  // block idle: nothing queued, nothing offered, nothing owed
  task automatic drain();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || in_valid_i || expected_rows.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned total;
    int unsigned phase;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    in_word_i         = '0;
    out_stall_i       = 1'b0;
    flow              = FlowFree;
    force_frame_start = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    img_width         = ImgWidthRstC;
    img_height        = ImgHeightRstC;
    row_pos           = 0;
    col_pos           = 0;
    for (int i = 0; i < MaxWidthC; i++) begin
      prev2_line[i] = 8'h00;
      prev1_line[i] = 8'h00;
    end
    for (int i = 0; i < 6; i++) col_hist[i] = 8'h00;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry, top row only: no tile can finish yet
    add_pixel(8'h00, 1'b1);
    add_pixel(8'hff, 1'b0);
    add_pixel(8'h80, 1'b0);
    drain();

    // full 3x3 frame of extremes: every edge and corner tile
    set_frame(3, 3, FlowFree);
    add_pixel(8'h00, 1'b1);
    add_pixel(8'hff, 1'b0);
    add_pixel(8'h00, 1'b0);
    add_pixel(8'hff, 1'b0);
    add_pixel(8'h00, 1'b0);
    add_pixel(8'hff, 1'b0);
    add_pixel(8'h00, 1'b0);
    add_pixel(8'hff, 1'b0);
    add_pixel(8'hff, 1'b0);
    drain();

    // stop mid-frame, then narrow the line: position falls out and restarts
    add_pixel(rand_pixel(), 1'b1);
    add_pixel(rand_pixel(), 1'b0);
    add_pixel(rand_pixel(), 1'b0);
    add_pixel(rand_pixel(), 1'b0);
    drain();
    set_frame(1, 3, FlowFree);
    add_pixel(rand_pixel(), 1'b0);
    add_pixel(rand_pixel(), 1'b0);
    add_pixel(rand_pixel(), 1'b0);
    drain();

    // zero width and zero height act as one: every pixel is its own frame
    set_frame(0, 0, FlowFree);
    add_pixel(8'hff, 1'b0);
    add_pixel(8'h00, 1'b0);
    drain();

    // oversized width clamps to the full line, one row, a short stretch of it
    set_frame((1 << ImgWidthW) - 1, 1, FlowBoth);
    for (int i = 0; i < 24; i++) add_pixel(rand_pixel(), 1'b0);
    drain();

    // tallest frame on a one-pixel line, partial
    set_frame(1, (1 << ImgHeightW) - 1, FlowSinkStalls);
    for (int i = 0; i < 40; i++) add_pixel(rand_pixel(), 1'b0);
    drain();

    // random small frames, whole and partial, with stray frame starts
    total = 0;
    phase = 0;
    while (total < RandomPixels) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      if ($urandom_range(19) == 0) w = 0;
      if ($urandom_range(19) == 0) h = 0;
      n = eff_width(w) * eff_height(h) * $urandom_range(1, 2);
      if ($urandom_range(3) == 0) n = $urandom_range(1, n);
      if (n > 90) n = 90;
      set_frame(w, h, flow_e'(phase % 4));
      for (int i = 0; i < n; i++) begin
        add_pixel(rand_pixel(), (i == 0 && $urandom_range(1) == 1) ||
                                $urandom_range(59) == 0);
      end
      total += n;
      phase++;
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
